>>> rtl/b2d_pkg.sv
// Shared constants and controller/datapath handshake types for the decimal digit streamer.
package b2d_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int MAX_DIGITS_DEF = 20;
	localparam int VALUE_PORT_BITS = 64;
	localparam int DIGIT_BITS = 4;
	localparam int BITS_PER_ROUND = 4;
	localparam int CHAR_BITS = 6;
	localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic convert;
		logic count;
		logic emit;
	} b2d_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic conv_done;
		logic emit_last;
		logic out_free;
	} b2d_sts_t;

endpackage

>>> rtl/b2d_ctrl.sv
// Controller state machine: load, convert, count digits, emit digit words.
module b2d_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  b2d_pkg::b2d_sts_t sts,
	output b2d_pkg::b2d_cmd_t cmd
);
	import b2d_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CONV  = 2'd1;
	localparam logic [1:0] ST_COUNT = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CONV;
				end
			end
			ST_CONV: begin
				cmd.convert = 1'b1;
				if (sts.conv_done) begin
					state_d = ST_COUNT;
				end
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				state_d   = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/b2d_dp.sv
// Datapath: shift-add-3 binary to BCD converter, digit counter and output word register.
module b2d_dp #(
	parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEF,
	parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [b2d_pkg::VALUE_PORT_BITS-1:0]  value,
	input  logic                                 msd_first,
	input  b2d_pkg::b2d_cmd_t                    cmd,
	output b2d_pkg::b2d_sts_t                    sts,
	output logic [b2d_pkg::CHAR_BITS-1:0]        digit_char,
	output logic                                 last,
	output logic                                 out_valid,
	input  logic                                 out_ready
);
	import b2d_pkg::*;

	localparam int PAD_BITS = ((VALUE_BITS + BITS_PER_ROUND - 1) / BITS_PER_ROUND)
		* BITS_PER_ROUND;
	localparam int ROUNDS   = PAD_BITS / BITS_PER_ROUND;
	localparam int RND_W    = $clog2(ROUNDS + 1);
	localparam int BCD_BITS = MAX_DIGITS * DIGIT_BITS;
	localparam int IDX_W    = $clog2(MAX_DIGITS);
	localparam int CNT_W    = $clog2(MAX_DIGITS + 1);

	logic [PAD_BITS-1:0]   shift_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic                  ovf_q;
	logic [RND_W-1:0]      round_q;
	logic                  msd_q;
	logic [IDX_W-1:0]      idx_q;
	logic [CNT_W-1:0]      left_q;
	logic [CHAR_BITS-1:0]  digit_q;
	logic                  last_q;
	logic                  out_valid_q;

	logic [BCD_BITS-1:0]   bcd_d;
	logic                  ovf_d;
	logic [CNT_W-1:0]      hi_c;
	logic [CNT_W-1:0]      n_c;
	logic [DIGIT_BITS-1:0] cur_digit;

	// one round: per bit, add 3 to every digit of five or more, then shift the bit in
	always_comb begin
		bcd_d = bcd_q;
		ovf_d = ovf_q;
		for (int j = 0; j < BITS_PER_ROUND; j++) begin
			for (int d = 0; d < MAX_DIGITS; d++) begin
				if (bcd_d[d*DIGIT_BITS +: DIGIT_BITS] >= DIGIT_BITS'(5)) begin
					bcd_d[d*DIGIT_BITS +: DIGIT_BITS] =
						bcd_d[d*DIGIT_BITS +: DIGIT_BITS] + DIGIT_BITS'(3);
				end
			end
			ovf_d = ovf_d | bcd_d[BCD_BITS-1];
			bcd_d = {bcd_d[BCD_BITS-2:0], shift_q[PAD_BITS-1-j]};
		end
	end

	// digit count: highest nonzero digit, at least one, all kept digits on overflow
	always_comb begin
		hi_c = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_BITS +: DIGIT_BITS] != '0) begin
				hi_c = CNT_W'(i + 1);
			end
		end
		if (ovf_q) begin
			n_c = CNT_W'(MAX_DIGITS);
		end else if (hi_c == '0) begin
			n_c = CNT_W'(1);
		end else begin
			n_c = hi_c;
		end
	end

	assign cur_digit     = bcd_q[idx_q*DIGIT_BITS +: DIGIT_BITS];
	assign sts.conv_done = (round_q == RND_W'(ROUNDS - 1));
	assign sts.emit_last = (left_q == CNT_W'(1));
	assign sts.out_free  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			shift_q <= PAD_BITS'(value[VALUE_BITS-1:0]);
			bcd_q   <= '0;
			ovf_q   <= 1'b0;
			round_q <= '0;
			msd_q   <= msd_first;
		end else if (cmd.convert) begin
			shift_q <= shift_q << BITS_PER_ROUND;
			bcd_q   <= bcd_d;
			ovf_q   <= ovf_d;
			round_q <= round_q + RND_W'(1);
		end
		if (cmd.count) begin
			left_q <= n_c;
			idx_q  <= msd_q ? IDX_W'(n_c - CNT_W'(1)) : '0;
		end else if (cmd.emit) begin
			left_q <= left_q - CNT_W'(1);
			idx_q  <= msd_q ? idx_q - IDX_W'(1) : idx_q + IDX_W'(1);
		end
		if (cmd.emit) begin
			digit_q <= ASCII_ZERO + CHAR_BITS'(cur_digit);
			last_q  <= (left_q == CNT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign digit_char = digit_q;
	assign last       = last_q;
	assign out_valid  = out_valid_q;

endmodule

>>> rtl/binary_to_decimal_digit_stream_top.sv
// Flow: a value is loaded, then converted by the shift-add-3 converter at four value bits
//   per cycle in ROUNDS rounds, where ROUNDS = ceil(VALUE_BITS / 4) (16 at 64 bits); its
//   N digits (1 to MAX_DIGITS) are then counted and emitted, one word per cycle while
//   out_ready does not stall the output register. No new value is taken before the last word.
// A new value is accepted while the last digit word of the previous one waits.
// Reset (arst_n, asynchronous, active low) empties the output register and idles the controller.
module binary_to_decimal_digit_stream_top #(
	parameter int VALUE_BITS = b2d_pkg::VALUE_BITS_DEF,
	parameter int MAX_DIGITS = b2d_pkg::MAX_DIGITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input word: value and digit order
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [b2d_pkg::VALUE_PORT_BITS-1:0] value,
	input  logic                                msd_first,
	// output word: one ASCII digit and the end-of-run mark
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [b2d_pkg::CHAR_BITS-1:0]       digit_char,
	output logic                                last
);
	import b2d_pkg::*;

	b2d_cmd_t cmd;
	b2d_sts_t sts;

	// sequence load, conversion rounds, digit count and emission
	b2d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hold the value, build the BCD digits, drive the output word register
	b2d_dp #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.msd_first  (msd_first),
		.cmd        (cmd),
		.sts        (sts),
		.digit_char (digit_char),
		.last       (last),
		.out_valid  (out_valid),
		.out_ready  (out_ready)
	);

endmodule
